/* rtl/assert_macros.svh */
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequent, outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error("implication check failed");

// Check that a condition holds at every edge, outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("invariant check failed");

`endif

/* rtl/tcgw_pkg.sv */
// Types, widths and arithmetic helpers for the triangle gradient weight block.
`timescale 1ns / 1ps
`default_nettype none
package tcgw_pkg;

	localparam int COORD_W     = 32;
	localparam int FIELD_W     = 32;
	localparam int THR_W       = 16;
	localparam int THR_SH      = 32;
	localparam int NUM_SH      = 64;
	localparam int AREA_SH     = 34;
	localparam int WQ_W        = 32;
	localparam int AREA_OUT_W  = 64;

	localparam int DIFF_W      = COORD_W + 1;
	localparam int LIMB_W      = DIFF_W;
	localparam int PROD_W      = 2 * DIFF_W;
	localparam int CROSS_W     = PROD_W + 1;
	localparam int MAG_W       = PROD_W;
	localparam int SQ_W        = 2 * MAG_W;
	localparam int S_LIMBS     = SQ_W / LIMB_W;
	localparam int P_LIMBS     = MAG_W / LIMB_W;
	localparam int M_W         = MAG_W + SQ_W;
	localparam int DD_W        = SQ_W + NUM_SH;
	localparam int AQ_W        = (SQ_W - AREA_SH + 1) / 2;
	localparam int R1_W        = MAG_W + 2 * WQ_W + 1;
	localparam int R2_W        = M_W + 2 * WQ_W + 1;
	localparam int RA_W        = 2 * AQ_W + 1;
	localparam int ROOT_STAGES = AQ_W;
	localparam int RESULT_LAT  = ROOT_STAGES + 11;

	typedef struct packed {
		logic signed [FIELD_W-1:0] a_x;
		logic signed [FIELD_W-1:0] a_y;
		logic signed [FIELD_W-1:0] a_z;
		logic signed [FIELD_W-1:0] b_x;
		logic signed [FIELD_W-1:0] b_y;
		logic signed [FIELD_W-1:0] b_z;
		logic signed [FIELD_W-1:0] c_x;
		logic signed [FIELD_W-1:0] c_y;
		logic signed [FIELD_W-1:0] c_z;
	} vtx_t;

	typedef struct packed {
		logic                      ok;
		logic signed [WQ_W-1:0]    weight_first;
		logic signed [WQ_W-1:0]    weight_second;
		logic [AREA_OUT_W-1:0]     tri_area;
	} res_t;

	typedef struct packed {
		logic [2:0][MAG_W-1:0] crm;
		logic [MAG_W-1:0]      dotm;
		logic                  neg;
		logic [MAG_W-1:0]      p;
		logic                  pbad;
	} fq_t;

	typedef struct packed {
		logic             take;
		logic [R2_W-1:0]  r;
		logic [R2_W-1:0]  u;
	} root_t;

	function automatic logic [MAG_W-1:0] mag_of(input logic signed [CROSS_W-1:0] v);
		logic [CROSS_W-1:0] n;
		n = -v;
		return v[CROSS_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
	endfunction

	// One bit of the search for the largest q with q*q*m <= r0.
	// r holds r0 - q*q*m, u holds q*m.
	function automatic root_t root_step(input logic [R2_W-1:0] r, input logic [R2_W-1:0] u,
		input logic [R2_W-1:0] m, input int b);
		root_t o;
		logic [R2_W-1:0] term;
		term   = (u << (b + 1)) + (m << (2 * b));
		o.take = (term <= r);
		o.r    = o.take ? (r - term) : r;
		o.u    = o.take ? (u + (m << b)) : u;
		return o;
	endfunction

endpackage
`default_nettype wire

/* rtl/tcgw_front.sv */
// Front end: accepts vertices, forms edges, cross, dot and squared edge length.
`timescale 1ns / 1ps
`default_nettype none
module tcgw_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      adv,
	input  tcgw_pkg::vtx_t            vtx,
	input  logic [tcgw_pkg::THR_W-1:0] thr,
	output logic                      push,
	output tcgw_pkg::fq_t             fq
);
	import tcgw_pkg::*;

	logic signed [COORD_W-1:0] va [3];
	logic signed [COORD_W-1:0] vb [3];
	logic signed [COORD_W-1:0] vc [3];
	logic signed [DIFF_W-1:0]  d1_s1 [3];
	logic signed [DIFF_W-1:0]  d2_s1 [3];
	logic signed [PROD_W-1:0]  pc_s2 [3];
	logic signed [PROD_W-1:0]  pn_s2 [3];
	logic signed [PROD_W-1:0]  pd_s2 [3];
	logic signed [PROD_W-1:0]  pp_s2 [3];
	logic                      vld_s1, vld_s2, vld_s3;
	fq_t                       fq_d, fq_s3;
	logic [2*THR_W-1:0]        thr2;

	always_comb begin
		va[0] = vtx.a_x[COORD_W-1:0];
		va[1] = vtx.a_y[COORD_W-1:0];
		va[2] = vtx.a_z[COORD_W-1:0];
		vb[0] = vtx.b_x[COORD_W-1:0];
		vb[1] = vtx.b_y[COORD_W-1:0];
		vb[2] = vtx.b_z[COORD_W-1:0];
		vc[0] = vtx.c_x[COORD_W-1:0];
		vc[1] = vtx.c_y[COORD_W-1:0];
		vc[2] = vtx.c_z[COORD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				d1_s1[i] <= DIFF_W'(vb[i]) - DIFF_W'(va[i]);
				d2_s1[i] <= DIFF_W'(vc[i]) - DIFF_W'(va[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				pc_s2[i] <= PROD_W'(d1_s1[(i + 1) % 3]) * PROD_W'(d2_s1[(i + 2) % 3]);
				pn_s2[i] <= PROD_W'(d1_s1[(i + 2) % 3]) * PROD_W'(d2_s1[(i + 1) % 3]);
				pd_s2[i] <= PROD_W'(d1_s1[i]) * PROD_W'(d2_s1[i]);
				pp_s2[i] <= PROD_W'(d1_s1[i]) * PROD_W'(d1_s1[i]);
			end
		end
	end

	assign thr2 = (2 * THR_W)'(thr) * (2 * THR_W)'(thr);

	always_comb begin
		logic signed [CROSS_W-1:0] cr;
		logic signed [CROSS_W-1:0] dot;
		fq_d = '0;
		for (int i = 0; i < 3; i++) begin
			cr = CROSS_W'(pc_s2[i]) - CROSS_W'(pn_s2[i]);
			fq_d.crm[i] = mag_of(cr);
		end
		dot = CROSS_W'(pd_s2[0]) + CROSS_W'(pd_s2[1]) + CROSS_W'(pd_s2[2]);
		fq_d.dotm = mag_of(dot);
		fq_d.neg  = dot[CROSS_W-1];
		fq_d.p    = $unsigned(pp_s2[0]) + $unsigned(pp_s2[1]) + $unsigned(pp_s2[2]);
		fq_d.pbad = (fq_d.p == '0) || (fq_d.p < MAG_W'(thr2));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fq_s3 <= fq_d;
		end
	end

	assign push = vld_s3 && adv;
	assign fq   = fq_s3;

endmodule
`default_nettype wire

/* rtl/tcgw_queue.sv */
// Two-entry item queue between the front end and the root pipeline.
`timescale 1ns / 1ps
`default_nettype none
module tcgw_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tcgw_pkg::fq_t din,
	input  logic          pop,
	output logic          full,
	output logic          vld,
	output tcgw_pkg::fq_t dout
);
	import tcgw_pkg::*;

	fq_t        ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= din;
		end
	end

	assign full = (cnt_q == 2'd2);
	assign vld  = (cnt_q != 2'd0);
	assign dout = ent_q[rp_q];

endmodule
`default_nettype wire

/* rtl/tcgw_back.sv */
// Back end: squares, products and the bit-serial root pipeline for weights and area.
`timescale 1ns / 1ps
`default_nettype none
module tcgw_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_vld,
	input  tcgw_pkg::fq_t              in_fq,
	input  logic [tcgw_pkg::THR_W-1:0] thr,
	output logic                       pop,
	output logic                       done,
	output tcgw_pkg::res_t             res
);
	import tcgw_pkg::*;

	typedef struct packed {
		logic             bad;
		logic             neg;
		logic [MAG_W-1:0] p;
		logic [M_W-1:0]   m;
		logic [R1_W-1:0]  r1;
		logic [R1_W-1:0]  u1;
		logic [WQ_W-1:0]  q1;
		logic [R2_W-1:0]  r2;
		logic [R2_W-1:0]  u2;
		logic [WQ_W-1:0]  q2;
		logic [RA_W-1:0]  ra;
		logic [RA_W-1:0]  ua;
	} rt_t;

	localparam logic [WQ_W-1:0] NEG_MAG = {1'b1, {(WQ_W-1){1'b0}}};
	localparam logic [WQ_W-1:0] POS_MAG = {1'b0, {(WQ_W-1){1'b1}}};

	logic [MAG_W-1:0]  v [4];
	logic [MAG_W-1:0]  sqp_s1 [4][3];
	logic [MAG_W-1:0]  p_s1, p_s2, p_s3, p_s4, p_s5;
	logic              pbad_s1, pbad_s2;
	logic              neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [SQ_W-1:0]   sq_s2 [4];
	logic [SQ_W-1:0]   s_s3, s_s4, s_s5;
	logic [DD_W-1:0]   d_s3, d_s4, d_s5;
	logic              bad_s3, bad_s4, bad_s5;
	logic [MAG_W-1:0]  mp_s4 [P_LIMBS][S_LIMBS];
	logic [M_W-1:0]    mh_s5 [P_LIMBS];
	logic              vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic              rt_vld [ROOT_STAGES+1];
	rt_t               rt_s [ROOT_STAGES+1];
	logic [2*THR_W-1:0] thr2;
	logic              sbad;
	logic [SQ_W-1:0]   s_sum;
	logic [M_W-1:0]    m_sum;
	res_t              res_d, res_q;
	logic              done_q;

	assign pop  = in_vld;
	assign thr2 = (2 * THR_W)'(thr) * (2 * THR_W)'(thr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			for (int k = 0; k <= ROOT_STAGES; k++) begin
				rt_vld[k] <= 1'b0;
			end
			done_q <= 1'b0;
		end else begin
			vld_s1    <= in_vld;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			rt_vld[0] <= vld_s5;
			for (int k = 0; k < ROOT_STAGES; k++) begin
				rt_vld[k+1] <= rt_vld[k];
			end
			done_q <= rt_vld[ROOT_STAGES];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			v[i] = in_fq.crm[i];
		end
		v[3] = in_fq.dotm;
	end

	always_ff @(posedge clk) begin
		for (int n = 0; n < 4; n++) begin
			sqp_s1[n][0] <= MAG_W'(v[n][MAG_W-1:LIMB_W]) * MAG_W'(v[n][MAG_W-1:LIMB_W]);
			sqp_s1[n][1] <= MAG_W'(v[n][MAG_W-1:LIMB_W]) * MAG_W'(v[n][LIMB_W-1:0]);
			sqp_s1[n][2] <= MAG_W'(v[n][LIMB_W-1:0]) * MAG_W'(v[n][LIMB_W-1:0]);
		end
		p_s1    <= in_fq.p;
		pbad_s1 <= in_fq.pbad;
		neg_s1  <= in_fq.neg;
	end

	always_ff @(posedge clk) begin
		for (int n = 0; n < 4; n++) begin
			sq_s2[n] <= (SQ_W'(sqp_s1[n][0]) << (2 * LIMB_W))
				+ (SQ_W'(sqp_s1[n][1]) << (LIMB_W + 1)) + SQ_W'(sqp_s1[n][2]);
		end
		p_s2    <= p_s1;
		pbad_s2 <= pbad_s1;
		neg_s2  <= neg_s1;
	end

	assign s_sum = sq_s2[0] + sq_s2[1] + sq_s2[2];
	assign sbad  = (s_sum == '0) || (s_sum < (SQ_W'(thr2) << THR_SH));

	always_ff @(posedge clk) begin
		s_s3   <= s_sum;
		d_s3   <= DD_W'(sq_s2[3]) << NUM_SH;
		bad_s3 <= pbad_s2 || sbad;
		p_s3   <= p_s2;
		neg_s3 <= neg_s2;
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < P_LIMBS; j++) begin
			for (int i = 0; i < S_LIMBS; i++) begin
				mp_s4[j][i] <= MAG_W'(p_s3[j*LIMB_W +: LIMB_W])
					* MAG_W'(s_s3[i*LIMB_W +: LIMB_W]);
			end
		end
		s_s4   <= s_s3;
		d_s4   <= d_s3;
		bad_s4 <= bad_s3;
		p_s4   <= p_s3;
		neg_s4 <= neg_s3;
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < P_LIMBS; j++) begin
			logic [M_W-1:0] acc;
			acc = '0;
			for (int i = 0; i < S_LIMBS; i++) begin
				acc = acc + (M_W'(mp_s4[j][i]) << (i * LIMB_W));
			end
			mh_s5[j] <= acc;
		end
		s_s5   <= s_s4;
		d_s5   <= d_s4;
		bad_s5 <= bad_s4;
		p_s5   <= p_s4;
		neg_s5 <= neg_s4;
	end

	always_comb begin
		m_sum = '0;
		for (int j = 0; j < P_LIMBS; j++) begin
			m_sum = m_sum + (mh_s5[j] << (j * LIMB_W));
		end
	end

	always_ff @(posedge clk) begin
		rt_s[0].bad <= bad_s5;
		rt_s[0].neg <= neg_s5;
		rt_s[0].p   <= p_s5;
		rt_s[0].m   <= m_sum;
		rt_s[0].r1  <= R1_W'(1) << NUM_SH;
		rt_s[0].u1  <= '0;
		rt_s[0].q1  <= '0;
		rt_s[0].r2  <= R2_W'(d_s5);
		rt_s[0].u2  <= '0;
		rt_s[0].q2  <= '0;
		rt_s[0].ra  <= RA_W'(s_s5 >> AREA_SH);
		rt_s[0].ua  <= '0;
	end

	for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_root
		localparam int BA = ROOT_STAGES - 1 - k;
		if (k < WQ_W) begin : g_w
			localparam int BW = WQ_W - 1 - k;
			rt_t   nxt;
			root_t ta, t1, t2;
			always_comb begin
				nxt = rt_s[k];
				ta  = root_step(R2_W'(rt_s[k].ra), R2_W'(rt_s[k].ua), R2_W'(1), BA);
				t1  = root_step(R2_W'(rt_s[k].r1), R2_W'(rt_s[k].u1), R2_W'(rt_s[k].p), BW);
				t2  = root_step(rt_s[k].r2, rt_s[k].u2, R2_W'(rt_s[k].m), BW);
				nxt.ra = ta.r[RA_W-1:0];
				nxt.ua = ta.u[RA_W-1:0];
				nxt.r1 = t1.r[R1_W-1:0];
				nxt.u1 = t1.u[R1_W-1:0];
				nxt.q1 = rt_s[k].q1 | (WQ_W'(t1.take) << BW);
				nxt.r2 = t2.r;
				nxt.u2 = t2.u;
				nxt.q2 = rt_s[k].q2 | (WQ_W'(t2.take) << BW);
			end
			always_ff @(posedge clk) begin
				rt_s[k+1] <= nxt;
			end
		end else begin : g_a
			rt_t   nxt;
			root_t ta;
			always_comb begin
				nxt = rt_s[k];
				ta  = root_step(R2_W'(rt_s[k].ra), R2_W'(rt_s[k].ua), R2_W'(1), BA);
				nxt.ra = ta.r[RA_W-1:0];
				nxt.ua = ta.u[RA_W-1:0];
			end
			always_ff @(posedge clk) begin
				rt_s[k+1] <= nxt;
			end
		end
	end

	always_comb begin
		logic [WQ_W-1:0] m1, m2;
		res_d = '0;
		m1 = (rt_s[ROOT_STAGES].q1 > NEG_MAG) ? NEG_MAG : rt_s[ROOT_STAGES].q1;
		if (rt_s[ROOT_STAGES].neg) begin
			m2 = (rt_s[ROOT_STAGES].q2 > NEG_MAG) ? NEG_MAG : rt_s[ROOT_STAGES].q2;
		end else begin
			m2 = (rt_s[ROOT_STAGES].q2 > POS_MAG) ? POS_MAG : rt_s[ROOT_STAGES].q2;
		end
		if (!rt_s[ROOT_STAGES].bad) begin
			res_d.ok            = 1'b1;
			res_d.weight_first  = WQ_W'(0) - m1;
			res_d.weight_second = rt_s[ROOT_STAGES].neg ? (WQ_W'(0) - m2) : m2;
			res_d.tri_area      = AREA_OUT_W'(rt_s[ROOT_STAGES].ua[AQ_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	assign done = done_q;
	assign res  = res_q;

endmodule
`default_nettype wire

/* rtl/triangle_conformal_gradient_weights.sv */
// Top level of the triangle conformal gradient weight block.
// Throughput: one item per cycle; the 49-step area root pipeline sets the depth.
// busy stays low in use: the root pipeline drains the queue every cycle.
// Reset clears all valid bits and the queue, and sets the threshold to 1.
`timescale 1ns / 1ps
`default_nettype none
module triangle_conformal_gradient_weights (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  tcgw_pkg::vtx_t             vtx,
	input  logic                       cfg_we,
	input  logic [tcgw_pkg::THR_W-1:0] cfg_wdata,
	output logic                       done,
	output tcgw_pkg::res_t             res
);
	import tcgw_pkg::*;

	logic [THR_W-1:0] thr_q;
	logic             push, full, q_vld, pop;
	fq_t              fq, q_fq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_W'(1);
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	assign busy = full;

	tcgw_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.adv    (!full),
		.vtx    (vtx),
		.thr    (thr_q),
		.push   (push),
		.fq     (fq)
	);

	tcgw_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (fq),
		.pop    (pop),
		.full   (full),
		.vld    (q_vld),
		.dout   (q_fq)
	);

	tcgw_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (q_vld),
		.in_fq  (q_fq),
		.thr    (thr_q),
		.pop    (pop),
		.done   (done),
		.res    (res)
	);

endmodule
`default_nettype wire

/* rtl/tcgw_chk.sv */
// Port-level checker for the triangle gradient weight block, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tcgw_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input tcgw_pkg::res_t res
);
	import tcgw_pkg::*;

	logic res_zero;
	logic first_nonpos;

	assign res_zero = (res.weight_first == '0) && (res.weight_second == '0)
		&& (res.tri_area == '0);
	assign first_nonpos = res.weight_first[WQ_W-1] || (res.weight_first == '0);

	`ASSERT_IMPLY(a_item_done, clk, arst_n, start && !busy, ##RESULT_LAT done)
	`ASSERT_IMPLY(a_done_src, clk, arst_n, done, $past(start && !busy, RESULT_LAT))
	`ASSERT_IMPLY(a_degen_zero, clk, arst_n, done && !res.ok, res_zero)
	`ASSERT_IMPLY(a_first_sign, clk, arst_n, done && res.ok, first_nonpos)

endmodule

bind triangle_conformal_gradient_weights tcgw_chk u_chk (.*);
`default_nettype wire
